### hdl/rfcc_pkg.sv
// ----------------------------------------------------------------------------
// rfcc_pkg : response frame CRC checker package
// Status codes, frame constants and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
`default_nettype none

package rfcc_pkg;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_COUNT = 2'd1,
      ST_SHORT = 2'd2,
      ST_CRC   = 2'd3
   } status_type;

   localparam logic [15:0] CRC_POLY      = 16'h8005;
   localparam int          CRC_TOP_BIT   = 15;
   localparam logic [7:0]  MIN_FRAME     = 8'd3;
   localparam logic [7:0]  MAX_LEN_RESET = 8'd35;

   // one byte into the CRC, least significant bit first, register not reflected
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                              input logic [7:0]  data);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         fb = data[i] ^ c[CRC_TOP_BIT];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### hdl/response_frame_crc_checker.sv
// ----------------------------------------------------------------------------
// response_frame_crc_checker
// Checks a received response frame byte by byte: count byte, length limit
// and trailing little-endian CRC-16 (poly 0x8005, init 0, LSB-first feed).
// ----------------------------------------------------------------------------
//
//  channel | direction | fields
//  --------+-----------+---------------------------------------------------
//  req_    | in        | tdata[7:0] data byte, tlast final byte of frame
//  rsp_    | out       | tdata status[1:0], frame_len[9:2], crc[25:10]
//  csr_    | in        | wr_data max_len, taken when wr_en is high
//
//  One byte is taken every cycle unless a final byte is stalled; each byte
//  passes an input register, one CRC byte update, and (on the final byte)
//  the result register, which drives rsp_tvalid. Reset is synchronous and
//  active high; it clears the frame state and sets max_len to 35. A final
//  byte waits in the input register only while an earlier result is still
//  held on rsp_.
// ----------------------------------------------------------------------------
`default_nettype none

module response_frame_crc_checker
   import rfcc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // input byte stream
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,    // data_byte[7:0]
   input  wire logic        req_tlast,    // last_byte
   // result stream
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,    // status[1:0], frame_len[9:2],
                                          // crc_value[25:10], zero[31:26]
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [7:0]  csr_wr_data   // max_len
);

   // configuration register
   logic [7:0]  max_len_ff;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_data_ff;
   logic        in_last_ff;

   // frame state
   logic [7:0]  byte_count_ff, byte_count_in;
   logic [7:0]  count_field_ff, count_field_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  tail0_ff, tail0_in;
   logic [7:0]  tail1_ff, tail1_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  status_ff, status_in;
   logic [7:0]  len_ff;
   logic [15:0] crc_out_ff;

   logic        stall;
   logic        proc;
   logic        keep;

   // handshake: only a final byte needs a free result slot
   assign stall      = in_valid_ff && in_last_ff && rsp_valid_ff && !rsp_tready;
   assign proc       = in_valid_ff && !stall;
   assign req_tready = !in_valid_ff || !stall;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 :
                         (proc ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (proc && in_last_ff) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   // frame update for the byte in the input register
   assign keep = byte_count_ff < max_len_ff;

   always_comb begin
      byte_count_in  = byte_count_ff;
      count_field_in = count_field_ff;
      crc_in         = crc_ff;
      tail0_in       = tail0_ff;
      tail1_in       = tail1_ff;
      if (keep) begin
         if (byte_count_ff >= 8'd2) begin
            crc_in = crc16_feed(crc_ff, tail0_ff);
         end
         tail0_in = tail1_ff;
         tail1_in = in_data_ff;
         if (byte_count_ff == 8'd0) begin
            count_field_in = in_data_ff;
         end
         byte_count_in = byte_count_ff + 8'd1;
      end
   end

   // checks in order: count, length, CRC
   always_comb begin
      if (byte_count_in == 8'd0 || count_field_in != byte_count_in) begin
         status_in = ST_COUNT;
      end else if (byte_count_in < MIN_FRAME) begin
         status_in = ST_SHORT;
      end else if (crc_in == {tail1_in, tail0_in}) begin
         status_in = ST_OK;
      end else begin
         status_in = ST_CRC;
      end
   end

   // control and frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff     <= MAX_LEN_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         byte_count_ff  <= '0;
         count_field_ff <= '0;
         crc_ff         <= '0;
         tail0_ff       <= '0;
         tail1_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (proc) begin
            if (in_last_ff) begin
               byte_count_ff  <= '0;
               count_field_ff <= '0;
               crc_ff         <= '0;
               tail0_ff       <= '0;
               tail1_ff       <= '0;
            end else begin
               byte_count_ff  <= byte_count_in;
               count_field_ff <= count_field_in;
               crc_ff         <= crc_in;
               tail0_ff       <= tail0_in;
               tail1_ff       <= tail1_in;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (proc && in_last_ff) begin
         status_ff  <= status_in;
         len_ff     <= byte_count_in;
         crc_out_ff <= crc_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, crc_out_ff, len_ff, status_ff};

`ifndef NO_ASSERTIONS
   // a final byte always leaves a cleared frame behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (proc && in_last_ff) |=> (byte_count_ff == 8'd0 && crc_ff == 16'd0))
      else $error("frame state not cleared after final byte");

   // a byte that is not final never raises a result
   a_no_result_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (proc && !in_last_ff && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result raised by a non-final byte");

   // an ok status needs at least the minimum frame length
   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff == ST_OK) |-> (len_ff >= MIN_FRAME))
      else $error("ok status on a short frame");

   // an empty frame is always a count mismatch with a zero CRC
   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && len_ff == 8'd0) |->
         (status_ff == ST_COUNT && crc_out_ff == 16'd0))
      else $error("empty frame reported wrongly");
`endif

endmodule

`default_nettype wire
